/* hdl/recs_pkg.sv */
// ----------------------------------------------------------------------------
// recs_pkg
// Shared constants, types and arithmetic helpers for the RGB exposure,
// contrast and saturation unit.
// ----------------------------------------------------------------------------
package recs_pkg;

  localparam int unsigned PixBits   = 16;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned NumStages = 5;

  localparam int unsigned EnW      = 3;
  localparam int unsigned GainW    = 16;
  localparam int unsigned FactW    = 14;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 2;

  localparam int unsigned GainFrac = 10;
  localparam int unsigned FactFrac = 12;
  localparam int unsigned LumaFrac = 16;

  localparam int unsigned ExpProdW = PixBits + GainW;
  localparam int unsigned DiffW    = PixBits + 1;
  localparam int unsigned MulW     = DiffW + FactW + 1;
  localparam int unsigned ShW      = MulW + 1 - FactFrac;
  localparam int unsigned SumW     = ShW + 1;
  localparam int unsigned LumaProdW = PixBits + LumaFrac;
  localparam int unsigned LumaSumW  = LumaProdW + 2;

  typedef logic [PixBits-1:0] pix_t;

  localparam pix_t PixMax  = '1;
  localparam pix_t MidGrey = {1'b1, {(PixBits-1){1'b0}}};

  localparam logic [CfgIdxW-1:0] RegStageEnable     = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegExposureGain    = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegContrastFactor  = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegSaturationFactor = CfgIdxW'(3);

  localparam int unsigned EnExposure   = 0;
  localparam int unsigned EnContrast   = 1;
  localparam int unsigned EnSaturation = 2;

  localparam logic [EnW-1:0]   StageEnableRst = '1;
  localparam logic [GainW-1:0] GainUnity      = GainW'(1) << GainFrac;
  localparam logic [FactW-1:0] FactUnity      = FactW'(1) << FactFrac;

  localparam logic [LumaFrac-1:0] LumaWr = LumaFrac'(13933);
  localparam logic [LumaFrac-1:0] LumaWg = LumaFrac'(46872);
  localparam logic [LumaFrac-1:0] LumaWb = LumaFrac'(4731);

  typedef struct packed {
    logic [NumStages-1:0] ld;
    logic [NumStages-1:0] vld;
  } pipe_ctl_t;

  function automatic pix_t sat_pix(input logic signed [SumW-1:0] x);
    pix_t res;
    if (x < 0) begin
      res = '0;
    end else if (|x[SumW-1:PixBits]) begin
      res = PixMax;
    end else begin
      res = x[PixBits-1:0];
    end
    return res;
  endfunction

  function automatic pix_t expose(input pix_t v, input logic [GainW-1:0] g);
    logic [ExpProdW-1:0]       p;
    logic [ExpProdW:0]         t;
    logic [ExpProdW-GainFrac:0] r;
    pix_t                      res;
    p = v * g;
    t = {1'b0, p} + (ExpProdW+1)'(1 << (GainFrac-1));
    r = t[ExpProdW:GainFrac];
    res = (|r[ExpProdW-GainFrac:PixBits]) ? PixMax : r[PixBits-1:0];
    return res;
  endfunction

  function automatic logic signed [ShW-1:0] scale_q12(input logic signed [DiffW-1:0] d,
                                                       input logic [FactW-1:0] f);
    logic signed [MulW-1:0] p;
    logic signed [MulW:0]   t;
    p = d * $signed({1'b0, f});
    t = $signed({p[MulW-1], p}) + $signed((MulW+1)'(1 << (FactFrac-1)));
    return $signed(t[MulW:FactFrac]);
  endfunction

  function automatic pix_t adjust_around(input pix_t c, input pix_t pivot,
                                         input logic [FactW-1:0] f);
    logic signed [DiffW-1:0] d;
    logic signed [ShW-1:0]   r;
    logic signed [SumW-1:0]  s;
    d = $signed({1'b0, c}) - $signed({1'b0, pivot});
    r = scale_q12(d, f);
    s = $signed({r[ShW-1], r}) + $signed({{(SumW-PixBits){1'b0}}, pivot});
    return sat_pix(s);
  endfunction

endpackage

/* hdl/recs_if.sv */
// ----------------------------------------------------------------------------
// recs_in_if / recs_out_if
// Valid/ready pixel channels of the RGB adjustment unit.
// ----------------------------------------------------------------------------
interface recs_in_if;
  logic          valid;
  logic          ready;
  recs_pkg::pix_t red_in;
  recs_pkg::pix_t green_in;
  recs_pkg::pix_t blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface recs_out_if;
  logic          valid;
  logic          ready;
  recs_pkg::pix_t red_out;
  recs_pkg::pix_t green_out;
  recs_pkg::pix_t blue_out;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  output ready);
endinterface

/* hdl/recs_pipe_ctrl.sv */
// ----------------------------------------------------------------------------
// recs_pipe_ctrl
// Valid tracking and per-stage load enables for the pixel pipeline; empty
// stages are filled even while the output stage is stalled.
// ----------------------------------------------------------------------------
module recs_pipe_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  out_ready_i,
  output logic                  in_ready_o,
  output recs_pkg::pipe_ctl_t   ctl_o
);

  logic [recs_pkg::NumStages-1:0] valid_q, valid_d;
  logic [recs_pkg::NumStages-1:0] rdy;
  logic [recs_pkg::NumStages-1:0] src_vld;
  logic [recs_pkg::NumStages-1:0] ld;

  always_comb begin
    rdy[recs_pkg::NumStages-1] = !valid_q[recs_pkg::NumStages-1] || out_ready_i;
    for (int k = recs_pkg::NumStages - 2; k >= 0; k--) begin
      rdy[k] = !valid_q[k] || rdy[k+1];
    end
    src_vld = {valid_q[recs_pkg::NumStages-2:0], in_valid_i};
    ld      = rdy & src_vld;
    valid_d = valid_q;
    for (int k = 0; k < recs_pkg::NumStages; k++) begin
      if (rdy[k]) begin
        valid_d[k] = src_vld[k];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o = rdy[0];
  assign ctl_o.ld   = ld;
  assign ctl_o.vld  = valid_q;

endmodule

/* hdl/rgb_exposure_contrast_saturation_unit.sv */
// ----------------------------------------------------------------------------
// rgb_exposure_contrast_saturation_unit
// Per-pixel exposure, contrast and saturation adjustment of RGB pixels.
// ----------------------------------------------------------------------------
// The unit accepts one pixel item per clock while it is ready and returns one
// adjusted item for each, in order: exposure, contrast, the three luma
// products, the luma sum and the chroma scaling each occupy one register
// stage, the last of which is the output register. Each stage holds its item
// while downstream is stalled, and empty stages keep filling, so input is
// only refused when all five stages hold items and the output is not taken.
// Configuration must be written while no items are in flight.
module rgb_exposure_contrast_saturation_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [recs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [recs_pkg::CfgDataW-1:0]     cfg_data_i,
  recs_in_if.sink                           in_i,
  recs_out_if.source                        out_o
);

  localparam int unsigned NCh = recs_pkg::NumChan;

  logic [recs_pkg::EnW-1:0]   stage_enable_q;
  logic [recs_pkg::GainW-1:0] exposure_gain_q;
  logic [recs_pkg::FactW-1:0] contrast_factor_q;
  logic [recs_pkg::FactW-1:0] saturation_factor_q;

  recs_pkg::pipe_ctl_t ctl;

  recs_pkg::pix_t ch_in [NCh];
  recs_pkg::pix_t expo_q [NCh];
  recs_pkg::pix_t cont_q [NCh];
  recs_pkg::pix_t prod_ch_q [NCh];
  logic [recs_pkg::LumaProdW-1:0] prod_q [NCh];
  recs_pkg::pix_t luma_ch_q [NCh];
  recs_pkg::pix_t luma_q;
  recs_pkg::pix_t out_q [NCh];

  logic [recs_pkg::LumaFrac-1:0] luma_w [NCh];
  logic [recs_pkg::LumaSumW-1:0] luma_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_enable_q      <= recs_pkg::StageEnableRst;
      exposure_gain_q     <= recs_pkg::GainUnity;
      contrast_factor_q   <= recs_pkg::FactUnity;
      saturation_factor_q <= recs_pkg::FactUnity;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        recs_pkg::RegStageEnable: begin
          stage_enable_q <= cfg_data_i[recs_pkg::EnW-1:0];
        end
        recs_pkg::RegExposureGain: begin
          exposure_gain_q <= cfg_data_i[recs_pkg::GainW-1:0];
        end
        recs_pkg::RegContrastFactor: begin
          contrast_factor_q <= cfg_data_i[recs_pkg::FactW-1:0];
        end
        recs_pkg::RegSaturationFactor: begin
          saturation_factor_q <= cfg_data_i[recs_pkg::FactW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  recs_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .out_ready_i (out_o.ready),
    .in_ready_o  (in_i.ready),
    .ctl_o       (ctl)
  );

  assign ch_in[0]  = in_i.red_in;
  assign ch_in[1]  = in_i.green_in;
  assign ch_in[2]  = in_i.blue_in;
  assign luma_w[0] = recs_pkg::LumaWr;
  assign luma_w[1] = recs_pkg::LumaWg;
  assign luma_w[2] = recs_pkg::LumaWb;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < NCh; c++) begin
      if (ctl.ld[0]) begin
        expo_q[c] <= stage_enable_q[recs_pkg::EnExposure]
                     ? recs_pkg::expose(ch_in[c], exposure_gain_q) : ch_in[c];
      end
      if (ctl.ld[1]) begin
        cont_q[c] <= stage_enable_q[recs_pkg::EnContrast]
                     ? recs_pkg::adjust_around(expo_q[c], recs_pkg::MidGrey,
                                               contrast_factor_q)
                     : expo_q[c];
      end
      if (ctl.ld[2]) begin
        prod_q[c]    <= cont_q[c] * luma_w[c];
        prod_ch_q[c] <= cont_q[c];
      end
      if (ctl.ld[3]) begin
        luma_ch_q[c] <= prod_ch_q[c];
      end
      if (ctl.ld[4]) begin
        out_q[c] <= stage_enable_q[recs_pkg::EnSaturation]
                    ? recs_pkg::adjust_around(luma_ch_q[c], luma_q, saturation_factor_q)
                    : luma_ch_q[c];
      end
    end
  end

  assign luma_sum = recs_pkg::LumaSumW'(prod_q[0]) + recs_pkg::LumaSumW'(prod_q[1])
                  + recs_pkg::LumaSumW'(prod_q[2])
                  + recs_pkg::LumaSumW'(1 << (recs_pkg::LumaFrac - 1));

  always_ff @(posedge clk_i) begin
    if (ctl.ld[3]) begin
      luma_q <= luma_sum[recs_pkg::LumaProdW-1:recs_pkg::LumaFrac];
    end
  end

  assign out_o.valid     = ctl.vld[recs_pkg::NumStages-1];
  assign out_o.red_out   = out_q[0];
  assign out_o.green_out = out_q[1];
  assign out_o.blue_out  = out_q[2];

endmodule

/* hdl/recs_checker.sv */
// ----------------------------------------------------------------------------
// recs_checker
// Port-level checks of the RGB adjustment unit, bound to the top level.
// ----------------------------------------------------------------------------
module recs_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input recs_pkg::pix_t       red_out_i,
  input recs_pkg::pix_t       green_out_i,
  input recs_pkg::pix_t       blue_out_i
);

  logic [3:0] occ_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
    end else begin
      occ_q <= occ_q + 4'(in_acc) - 4'(out_acc);
    end
  end

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= 4'(recs_pkg::NumStages))
    else $error("More items in flight than pipeline stages.");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> occ_q != 4'd0)
    else $error("Result item shown with no item in flight.");

  a_refuse_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> (out_valid_i && !out_ready_i && occ_q == 4'(recs_pkg::NumStages)))
    else $error("Input refused while the pipeline has room.");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(red_out_i)
      && $stable(green_out_i) && $stable(blue_out_i))
    else $error("Stalled result item changed.");

endmodule

bind rgb_exposure_contrast_saturation_unit recs_checker u_recs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .red_out_i   (out_o.red_out),
  .green_out_i (out_o.green_out),
  .blue_out_i  (out_o.blue_out)
);
